[rtl/core/ffac_pkg.sv]
package ffac_pkg;

	// Fixed-point constants of the level and gain math
	localparam int          FLOOR_DB_Q8    = 30720;
	localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;
	localparam logic [21:0] OCT_PER_DB_Q24 = 22'd2786635;
	localparam int          ROOT_COUNT     = 16;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_MODE            = 3'd0,
		CFG_THRESHOLD_DB    = 3'd1,
		CFG_COMP_FACTOR     = 3'd2,
		CFG_KNEE_HALF_WIDTH = 3'd3,
		CFG_KNEE_COEF       = 3'd4,
		CFG_ALPHA_ATTACK    = 3'd5,
		CFG_ALPHA_RELEASE   = 3'd6
	} cfg_idx_t;

	// Peak detector flavors
	typedef enum logic [1:0] {
		MODE_BRANCH           = 2'd0,
		MODE_BRANCH_SMOOTH    = 2'd1,
		MODE_DECOUPLED        = 2'd2,
		MODE_DECOUPLED_SMOOTH = 2'd3
	} det_mode_t;

	typedef struct packed {
		det_mode_t          mode;
		logic signed [15:0] threshold_db;
		logic [15:0]        comp_factor;
		logic [13:0]        knee_half_width;
		logic [15:0]        knee_coef;
		logic [15:0]        alpha_attack;
		logic [15:0]        alpha_release;
	} cfg_t;

	localparam logic signed [15:0] RST_THRESHOLD_DB = -16'sd5120;
	localparam logic [15:0]        RST_COMP_FACTOR  = 16'd49152;

	typedef enum logic [3:0] {
		F_IDLE, F_NORM, F_SQR, F_DB, F_LVL, F_OV, F_SQ, F_KC, F_RED, F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_DET, B_MA1, B_MA2, B_SMSET, B_EXP, B_ROOT, B_SHIFT, B_SCALE, B_PUSH
	} back_state_t;

	typedef logic [ROOT_COUNT-1:0][30:0] root_tab_t;

	// Bitwise integer square root, used only at elaboration
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != '0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Q0.30 roots 2^(-2^-(j+1)), each one the truncated root of the one before
	function automatic root_tab_t build_roots();
		root_tab_t   tab;
		logic [63:0] r;
		r = isqrt64(64'd1 << 59);
		tab[0] = r[30:0];
		for (int j = 1; j < ROOT_COUNT; j++) begin
			r = isqrt64(r << 30);
			tab[j] = r[30:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = build_roots();

endpackage

[rtl/core/feedforward_audio_compressor.sv]
// Feed-forward soft-knee compressor, one signed sample per transfer.
// Input side looks like a queue: drive in_sample with push while full is low.
// Result side looks like a queue: while empty is low, out_sample and gain_db
// hold the oldest result; pop takes it. Results come out in input order.
// Configuration goes over cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high, and registers should be written only while no sample is in flight.
// A front sequencer finds the sample level (leading zero search, then one
// squaring per log2 fraction bit) and the static gain reduction; a two-entry
// queue hands it to a back sequencer that runs the detector, the root product
// for 10^(gain/20) (one multiply per fraction bit) and the final scaling.
// Samples below the -120 dB floor skip the level search in the front. In the
// decoupled modes the back runs extra smoothing steps, more on release than
// on attack. Sustained rate is set by the slower sequencer.
// A stalled receiver fills the two-entry result queue, then the middle queue,
// then holds full high. Reset clears the queues, the detector states and the
// registers to their defaults.
module feedforward_audio_compressor import ffac_pkg::*; #(
	parameter int SAMPLE_BITS    = 24,
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic signed [15:0]            gain_db,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int MID_W = 15 + 1 + SAMPLE_BITS;
	localparam int OUT_W = 16 + SAMPLE_BITS;

	cfg_t cfg_q;

	logic                   mid_push;
	logic                   mid_full;
	logic                   mid_pop;
	logic                   mid_empty;
	logic [14:0]            f_red;
	logic                   f_negx;
	logic [SAMPLE_BITS-1:0] f_mag;
	logic [MID_W-1:0]       mid_rd;
	logic                   out_push;
	logic                   out_full;
	logic [SAMPLE_BITS-1:0] b_sample;
	logic [15:0]            b_gain;
	logic [OUT_W-1:0]       out_rd;

	assign cfg_ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= MODE_BRANCH;
			cfg_q.threshold_db    <= RST_THRESHOLD_DB;
			cfg_q.comp_factor     <= RST_COMP_FACTOR;
			cfg_q.knee_half_width <= '0;
			cfg_q.knee_coef       <= '0;
			cfg_q.alpha_attack    <= '0;
			cfg_q.alpha_release   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:            cfg_q.mode            <= det_mode_t'(cfg_data[1:0]);
				CFG_THRESHOLD_DB:    cfg_q.threshold_db    <= $signed(cfg_data);
				CFG_COMP_FACTOR:     cfg_q.comp_factor     <= cfg_data;
				CFG_KNEE_HALF_WIDTH: cfg_q.knee_half_width <= cfg_data[13:0];
				CFG_KNEE_COEF:       cfg_q.knee_coef       <= cfg_data;
				CFG_ALPHA_ATTACK:    cfg_q.alpha_attack    <= cfg_data;
				CFG_ALPHA_RELEASE:   cfg_q.alpha_release   <= cfg_data;
				default: ;
			endcase
		end
	end

	ffac_front #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.in_sample(in_sample),
		.mid_push (mid_push),
		.mid_full (mid_full),
		.mid_red  (f_red),
		.mid_negx (f_negx),
		.mid_mag  (f_mag)
	);

	ffac_fifo #(
		.WIDTH(MID_W),
		.DEPTH(2)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.wr_data({f_red, f_negx, f_mag}),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.rd_data(mid_rd)
	);

	ffac_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_red   (mid_rd[MID_W-1 -: 15]),
		.mid_negx  (mid_rd[SAMPLE_BITS]),
		.mid_mag   (mid_rd[SAMPLE_BITS-1:0]),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_sample(b_sample),
		.out_gain  (b_gain)
	);

	ffac_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(2)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.wr_data({b_gain, b_sample}),
		.pop    (pop),
		.empty  (empty),
		.rd_data(out_rd)
	);

	assign gain_db    = $signed(out_rd[OUT_W-1 -: 16]);
	assign out_sample = $signed(out_rd[SAMPLE_BITS-1:0]);

	// The front takes one sample at a time
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front accepted a sample without going busy");

	// The back never drains an empty middle queue
	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back popped an empty middle queue");

	// Offered gain stays within the floor and unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (gain_db <= 16'sd0 && gain_db >= -16'sd30720))
		else $error("gain out of range");

endmodule

[rtl/core/ffac_fifo.sv]
module ffac_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = push && !full;
	assign do_rd   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the entry on a write transfer
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/core/ffac_front.sv]
module ffac_front import ffac_pkg::*; #(
	parameter int SAMPLE_BITS    = 24,
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	output logic                   mid_push,
	input  logic                   mid_full,
	output logic [14:0]            mid_red,
	output logic                   mid_negx,
	output logic [SAMPLE_BITS-1:0] mid_mag
);

	localparam int SB     = SAMPLE_BITS;
	localparam int LTB    = LOG_TABLE_BITS;
	localparam int NS     = $clog2(SB);
	localparam int STEP_W = (NS > 1) ? $clog2(NS) : 1;
	localparam int CNT_W  = $clog2(LTB);
	localparam logic [63:0] FLOOR_MAG = (64'd1 << (SB - 1)) / 64'd1000000;
	localparam logic signed [15:0] LVL_FLOOR = -16'sd30720;

	front_state_t state_q, state_d;

	logic [SB-1:0]        mag_q;
	logic                 negx_q;
	logic [SB-1:0]        nrm_q;
	logic [NS-1:0]        lz_q;
	logic [STEP_W-1:0]    step_q;
	logic [30:0]          y_q;
	logic [LTB-1:0]       frac_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [45:0]          acc_q;
	logic signed [15:0]   lvl_q;
	logic signed [17:0]   ov_q;
	logic                 knee_q;
	logic [14:0]          d_q;
	logic [21:0]          rect_q;
	logic [14:0]          c_q;

	logic [SB-1:0]        mag_c;
	logic                 floor_c;
	logic [NS-1:0]        shamt_c;
	logic [SB-1:0]        top_mask_c;
	logic                 top_zero_c;
	logic [SB-1:0]        nrm_next_c;
	logic [SB+30:0]       wide_c;
	logic [61:0]          sqp_c;
	logic [31:0]          sq_c;
	logic [NS+LTB-1:0]    oct_c;
	logic [NS+15:0]       neg_c;
	logic [21:0]          dbm_c;
	logic [14:0]          dbc_c;
	logic signed [15:0]   lvl_c;
	logic signed [17:0]   ov_c;
	logic signed [17:0]   w_c;
	logic signed [17:0]   dsum_c;
	logic                 knee_c;
	logic [45:0]          kprod_c;
	logic [21:0]          rect_c;
	logic [37:0]          rp_c;
	logic [21:0]          red_c;

	// Magnitude of the incoming sample and the silence floor check
	assign mag_c   = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;
	assign floor_c = ({{(64-SB){1'b0}}, mag_c} <= FLOOR_MAG);

	// One binary-search step of the leading zero count
	assign shamt_c    = NS'(1) << step_q;
	assign top_mask_c = ~({SB{1'b1}} >> shamt_c);
	assign top_zero_c = ((nrm_q & top_mask_c) == '0);
	assign nrm_next_c = top_zero_c ? (nrm_q << shamt_c) : nrm_q;
	assign wide_c     = {nrm_next_c, 31'b0};

	// One squaring step of the log2 fraction
	assign sqp_c = 62'(y_q) * 62'(y_q);
	assign sq_c  = sqp_c[61:30];

	// Octaves below full scale, to dB
	assign oct_c = {lz_q, {LTB{1'b0}}} - {{NS{1'b0}}, frac_q};
	assign neg_c = {oct_c, {(16-LTB){1'b0}}};
	assign dbm_c = acc_q[45:24];
	assign dbc_c = (dbm_c > 22'(FLOOR_DB_Q8)) ? 15'(FLOOR_DB_Q8) : dbm_c[14:0];
	assign lvl_c = -$signed({1'b0, dbc_c});

	// Overshoot and knee region
	assign ov_c   = {{2{lvl_q[15]}}, lvl_q} - {{2{cfg.threshold_db[15]}}, cfg.threshold_db};
	assign w_c    = $signed({4'b0, cfg.knee_half_width});
	assign dsum_c = ov_c + w_c;
	assign knee_c = (cfg.knee_half_width != '0) && (ov_c > -w_c) && (ov_c < w_c);

	// Static curve before and after the ratio
	assign kprod_c = 46'(cfg.knee_coef) * 46'(acc_q[29:0]);
	assign rect_c  = knee_q ? kprod_c[45:24] :
	                 ((ov_q > 18'sd0) ? 22'(ov_q[16:0]) : '0);
	assign rp_c    = 38'(rect_q) * 38'(cfg.comp_factor);
	assign red_c   = rp_c[37:16];

	assign mid_red  = c_q;
	assign mid_negx = negx_q;
	assign mid_mag  = mag_q;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step through level, curve and ratio for one sample
	always_comb begin
		state_d  = state_q;
		full     = (state_q != F_IDLE);
		mid_push = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (push) state_d = floor_c ? F_OV : F_NORM;
			end
			F_NORM: begin
				if (step_q == '0) state_d = F_SQR;
			end
			F_SQR: begin
				if (cnt_q == CNT_W'(LTB - 1)) state_d = F_DB;
			end
			F_DB:  state_d = F_LVL;
			F_LVL: state_d = F_OV;
			F_OV:  state_d = F_SQ;
			F_SQ:  state_d = F_KC;
			F_KC:  state_d = F_RED;
			F_RED: state_d = F_PUSH;
			F_PUSH: begin
				if (!mid_full) begin
					mid_push = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Datapath registers, loaded by the step in progress
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				mag_q  <= mag_c;
				nrm_q  <= mag_c;
				negx_q <= in_sample[SB-1];
				lz_q   <= '0;
				step_q <= STEP_W'(NS - 1);
				lvl_q  <= LVL_FLOOR;
			end
			F_NORM: begin
				nrm_q  <= nrm_next_c;
				if (top_zero_c) lz_q <= lz_q + shamt_c;
				step_q <= step_q - 1'b1;
				y_q    <= wide_c[SB+30 -: 31];
				frac_q <= '0;
				cnt_q  <= '0;
			end
			F_SQR: begin
				y_q    <= sq_c[31] ? sq_c[31:1] : sq_c[30:0];
				frac_q <= {frac_q[LTB-2:0], sq_c[31]};
				cnt_q  <= cnt_q + 1'b1;
			end
			F_DB: begin
				acc_q <= 46'(neg_c) * 46'(DB_PER_OCT_Q16) + 46'(64'd1 << 23);
			end
			F_LVL: begin
				lvl_q <= lvl_c;
			end
			F_OV: begin
				ov_q   <= ov_c;
				knee_q <= knee_c;
				d_q    <= dsum_c[14:0];
			end
			F_SQ: begin
				acc_q <= 46'(d_q) * 46'(d_q);
			end
			F_KC: begin
				rect_q <= rect_c;
			end
			F_RED: begin
				c_q <= (red_c > 22'(FLOOR_DB_Q8)) ? 15'(FLOOR_DB_Q8) : red_c[14:0];
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/ffac_back.sv]
module ffac_back import ffac_pkg::*; #(
	parameter int SAMPLE_BITS    = 24,
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   mid_empty,
	output logic                   mid_pop,
	input  logic [14:0]            mid_red,
	input  logic                   mid_negx,
	input  logic [SAMPLE_BITS-1:0] mid_mag,
	input  logic                   out_full,
	output logic                   out_push,
	output logic [SAMPLE_BITS-1:0] out_sample,
	output logic [15:0]            out_gain
);

	localparam int SB = SAMPLE_BITS;
	localparam int LTB = LOG_TABLE_BITS;
	localparam int JW = $clog2(LTB);
	localparam logic signed [SB+1:0] SAT_HI = (SB+2)'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic signed [SB+1:0] SAT_LO = -SAT_HI - $signed((SB+2)'(1));

	back_state_t state_q, state_d;

	logic [14:0]        c_q;
	logic [SB-1:0]      mag_q;
	logic               negx_q;
	logic [15:0]        det_q;
	logic [15:0]        sm_q;
	logic [15:0]        a_q;
	logic [15:0]        s_q;
	logic [15:0]        x_q;
	logic               tgt_sm_q;
	logic [32:0]        acc_q;
	logic [15:0]        lvl_q;
	logic [20:0]        t_q;
	logic [30:0]        g_q;
	logic [JW-1:0]      j_q;
	logic [SB:0]        y_q;

	logic               decoupled_c;
	logic               keep_x_c;
	logic               gt_c;
	logic [16:0]        inva_c;
	logic [32:0]        sum_c;
	logic [15:0]        mix_c;
	logic [37:0]        ep_c;
	logic [3:0]         qi_c;
	logic [61:0]        gp_c;
	logic [SB+30:0]     sp_c;
	logic signed [SB+1:0] pos_c;
	logic signed [SB+1:0] sval_c;
	logic signed [SB+1:0] sat_c;

	// Detector flavor and attack decision
	assign decoupled_c = (cfg.mode == MODE_DECOUPLED) || (cfg.mode == MODE_DECOUPLED_SMOOTH);
	assign keep_x_c    = (cfg.mode == MODE_BRANCH_SMOOTH) || (cfg.mode == MODE_DECOUPLED_SMOOTH);
	assign gt_c        = ({1'b0, c_q} > det_q);

	// Second half of the one-pole mix
	assign inva_c = 17'h10000 - {1'b0, a_q};
	assign sum_c  = acc_q + 33'(inva_c) * 33'(x_q);
	assign mix_c  = sum_c[31:16];

	// Attenuation in octaves, root product and scaling
	assign ep_c = 38'(lvl_q) * 38'(OCT_PER_DB_Q24);
	assign qi_c = 4'd15 - 4'(j_q);
	assign gp_c = 62'(g_q) * 62'(ROOT_TAB[4'(j_q)]);
	assign sp_c = (SB+31)'(mag_q) * (SB+31)'(g_q) + (SB+31)'(64'd1 << 29);

	// Apply sign and saturate
	assign pos_c  = $signed({1'b0, y_q});
	assign sval_c = negx_q ? -pos_c : pos_c;
	assign sat_c  = (sval_c > SAT_HI) ? SAT_HI : ((sval_c < SAT_LO) ? SAT_LO : sval_c);

	assign out_sample = sat_c[SB-1:0];
	assign out_gain   = 16'd0 - lvl_q;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step through detector, root product and scaling for one item
	always_comb begin
		state_d  = state_q;
		mid_pop  = 1'b0;
		out_push = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!mid_empty) begin
					mid_pop = 1'b1;
					state_d = B_DET;
				end
			end
			B_DET: state_d = (decoupled_c && gt_c) ? B_SMSET : B_MA1;
			B_MA1: state_d = B_MA2;
			B_MA2: state_d = (!tgt_sm_q && decoupled_c) ? B_SMSET : B_EXP;
			B_SMSET: state_d = B_MA1;
			B_EXP: state_d = B_ROOT;
			B_ROOT: begin
				if (j_q == JW'(LTB - 1)) state_d = B_SHIFT;
			end
			B_SHIFT: state_d = B_SCALE;
			B_SCALE: state_d = B_PUSH;
			B_PUSH: begin
				if (!out_full) begin
					out_push = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Detector states, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q <= '0;
			sm_q  <= '0;
		end else begin
			if (state_q == B_DET && decoupled_c && gt_c) det_q <= {1'b0, c_q};
			if (state_q == B_MA2) begin
				if (tgt_sm_q) sm_q <= mix_c;
				else det_q <= mix_c;
			end
		end
	end

	// Datapath registers, loaded by the step in progress
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				c_q    <= mid_red;
				mag_q  <= mid_mag;
				negx_q <= mid_negx;
			end
			B_DET: begin
				a_q      <= gt_c ? cfg.alpha_attack : cfg.alpha_release;
				s_q      <= det_q;
				x_q      <= (gt_c || keep_x_c) ? {1'b0, c_q} : '0;
				tgt_sm_q <= 1'b0;
			end
			B_MA1: begin
				acc_q <= 33'(a_q) * 33'(s_q);
			end
			B_MA2: begin
				lvl_q <= mix_c;
			end
			B_SMSET: begin
				a_q      <= cfg.alpha_attack;
				s_q      <= sm_q;
				x_q      <= det_q;
				tgt_sm_q <= 1'b1;
			end
			B_EXP: begin
				t_q <= ep_c[36:16];
				g_q <= 31'(64'd1 << 30);
				j_q <= '0;
			end
			B_ROOT: begin
				if (t_q[qi_c]) g_q <= gp_c[60:30];
				j_q <= j_q + 1'b1;
			end
			B_SHIFT: begin
				g_q <= (t_q[20:16] >= 5'd31) ? '0 : (g_q >> t_q[20:16]);
			end
			B_SCALE: begin
				y_q <= sp_c[SB+30:30];
			end
			default: ;
		endcase
	end

endmodule

[verif/tb_feedforward_audio_compressor.sv]
`timescale 1ns / 1ps

module tb_feedforward_audio_compressor import ffac_pkg::*;;

	localparam int SB = 24;
	localparam int LTB = 10;
	localparam int LIMIT_CYCLES = 400000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [SB-1:0] in_sample;
	logic empty;
	logic pop;
	logic signed [SB-1:0] out_sample;
	logic signed [15:0] gain_db;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	feedforward_audio_compressor #(.SAMPLE_BITS(SB), .LOG_TABLE_BITS(LTB)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_sample(in_sample),
		.empty(empty), .pop(pop), .out_sample(out_sample), .gain_db(gain_db),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		logic signed [SB-1:0] smp;
		logic signed [15:0] gain;
	} comp_result_t;

	// Predictor state and register copies
	det_mode_t p_mode;
	int p_thresh;
	longint unsigned p_factor, p_knee_w, p_knee_c, p_att, p_rel;
	longint unsigned p_det, p_smooth;
	longint unsigned root_q30 [16];

	logic signed [SB-1:0] sample_q[$];
	comp_result_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit stim_done = 0;

	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int sample_level_db(longint unsigned m);
		longint unsigned y, frac, neg, mag;
		int p;
		frac = 0;
		p = 0;
		if (m * 64'd1000000 <= (64'd1 << (SB - 1))) return -FLOOR_DB_Q8;
		while ((m >> (p + 1)) != 0) p++;
		y = (p <= 30) ? (m << (30 - p)) : (m >> (p - 30));
		for (int k = 0; k < LTB; k++) begin
			y = (y * y) >> 30;
			frac <<= 1;
			if (y >= (64'd2 << 30)) begin
				frac |= 1;
				y >>= 1;
			end
		end
		neg = ((longint'(SB - 1 - p)) << LTB) - frac;
		neg <<= (16 - LTB);
		mag = (neg * 64'd394566 + (64'd1 << 23)) >> 24;
		if (mag > FLOOR_DB_Q8) mag = FLOOR_DB_Q8;
		return -int'(mag);
	endfunction

	function automatic longint unsigned blend(longint unsigned a, longint unsigned s,
			longint unsigned x);
		return (a * s + (65536 - a) * x) >> 16;
	endfunction

	// Compute the compressed sample and gain, advancing detector state
	function automatic comp_result_t compress(logic signed [SB-1:0] smp);
		comp_result_t r;
		longint signed xs, ov, w, res;
		longint unsigned mag, rect, red, c, s, t, g, n, q, y, d;
		xs = smp;
		mag = xs < 0 ? -xs : xs;
		ov = longint'(sample_level_db(mag)) - p_thresh;
		w = p_knee_w;
		if (w > 0 && ov > -w && ov < w) begin
			d = ov + w;
			rect = (p_knee_c * d * d) >> 24;
		end else begin
			rect = ov > 0 ? ov : 0;
		end
		red = (rect * p_factor) >> 16;
		c = red > FLOOR_DB_Q8 ? FLOOR_DB_Q8 : red;
		case (p_mode)
			MODE_BRANCH: begin
				p_det = c > p_det ? blend(p_att, p_det, c) : (p_rel * p_det) >> 16;
				s = p_det;
			end
			MODE_BRANCH_SMOOTH: begin
				p_det = c > p_det ? blend(p_att, p_det, c) : blend(p_rel, p_det, c);
				s = p_det;
			end
			MODE_DECOUPLED: begin
				p_det = c > p_det ? c : (p_rel * p_det) >> 16;
				p_smooth = blend(p_att, p_smooth, p_det);
				s = p_smooth;
			end
			default: begin
				p_det = c > p_det ? c : blend(p_rel, p_det, c);
				p_smooth = blend(p_att, p_smooth, p_det);
				s = p_smooth;
			end
		endcase
		t = (s * 64'd2786635) >> 16;
		n = t >> 16;
		q = (t & 64'hFFFF) >> (16 - LTB);
		g = 64'd1 << 30;
		for (int j = 0; j < LTB; j++)
			if ((q >> (LTB - 1 - j)) & 1) g = (g * root_q30[j]) >> 30;
		g = n >= 31 ? 0 : (g >> n);
		y = (mag * g + (64'd1 << 29)) >> 30;
		res = xs < 0 ? -longint'(y) : longint'(y);
		if (res > (64'sd1 << (SB - 1)) - 1) res = (64'sd1 << (SB - 1)) - 1;
		if (res < -(64'sd1 << (SB - 1))) res = -(64'sd1 << (SB - 1));
		r.smp = res[SB-1:0];
		r.gain = -longint'(s);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Write one register while the block is idle
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE:            p_mode = det_mode_t'(val[1:0]);
			CFG_THRESHOLD_DB:    p_thresh = $signed(val);
			CFG_COMP_FACTOR:     p_factor = val;
			CFG_KNEE_HALF_WIDTH: p_knee_w = val[13:0];
			CFG_KNEE_COEF:       p_knee_c = val;
			CFG_ALPHA_ATTACK:    p_att = val;
			default:             p_rel = val;
		endcase
	endtask

	task automatic drain_and_settle();
		while (sample_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		int sel;
		int e;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			// Log-spread magnitude to cover all levels
			e = $urandom_range(0, SB - 1);
			return $signed(SB'($urandom) >>> (SB - 1 - e)) ^ ($urandom_range(0, 1) ? '1 : '0);
		end else if (sel < 8) begin
			return SB'($urandom);
		end else begin
			return $urandom_range(0, 1) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
		end
	endfunction

	logic push_taken;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		push_taken <= push && !full;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Sender: bursts with random gaps, change on falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (push_taken) void'(sample_q.pop_front());
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				push <= 1'b0;
			end else if (push_taken && burst_left <= 1) begin
				burst_left <= $urandom_range(1, 20);
				gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
				push <= 1'b0;
			end else if (sample_q.size() > 0) begin
				push <= 1'b1;
				in_sample <= sample_q[0];
				if (push_taken) burst_left <= burst_left - 1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Predict at acceptance so config changes apply in order
	always @(posedge clk) begin
		if (arst_n && push && !full) expected_q.push_back(compress(in_sample));
	end

	// Receiver: stall pattern from a rotating random mask
	logic [15:0] stall_pat;
	int pat_pos = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			pat_pos <= pat_pos + 1;
			if (pat_pos % 300 == 0) stall_pat <= $urandom_range(0, 2) == 0 ? 16'h0 : 16'($urandom);
			pop <= !stall_pat[pat_pos % 16];
		end
	end

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin
		comp_result_t e;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", out_sample, 0);
			end else begin
				e = expected_q.pop_front();
				if (out_sample !== e.smp) report_mismatch("out_sample", out_sample, e.smp);
				if (gain_db !== e.gain) report_mismatch("gain_db", gain_db, e.gain);
			end
		end
	end

	task automatic run_phase(int count);
		for (int i = 0; i < count; i++) sample_q.push_back(rand_sample());
		drain_and_settle();
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		push = 0;
		push_taken = 0;
		pop = 0;
		in_sample = '0;
		cfg_valid = 0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		stall_pat = '0;
		root_q30[0] = int_sqrt((64'd1 << 29) << 30);
		for (int j = 1; j < 16; j++) root_q30[j] = int_sqrt(root_q30[j-1] << 30);
		p_mode = MODE_BRANCH;
		p_thresh = -5120;
		p_factor = 49152;
		p_knee_w = 0;
		p_knee_c = 0;
		p_att = 0;
		p_rel = 0;
		p_det = 0;
		p_smooth = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, floor, tiny, full scale, at default settings
		sample_q.push_back('0);
		sample_q.push_back(SB'(1));
		sample_q.push_back(-SB'(1));
		sample_q.push_back(SB'(8));
		sample_q.push_back(SB'(9));
		sample_q.push_back({1'b0, {(SB-1){1'b1}}});
		sample_q.push_back({1'b1, {(SB-1){1'b0}}});
		sample_q.push_back(SB'(24'h555555));
		sample_q.push_back(SB'(24'hAAAAAA));
		sample_q.push_back(SB'(24'h100000));
		drain_and_settle();

		// Soft knee, heavy compression, smoothing, every mode
		write_reg(CFG_KNEE_HALF_WIDTH, 16'd1536);
		write_reg(CFG_KNEE_COEF, 16'd2731);
		write_reg(CFG_THRESHOLD_DB, 16'hE800);
		for (int m = 0; m < 4; m++) begin
			write_reg(CFG_MODE, 16'(m));
			write_reg(CFG_ALPHA_ATTACK, 16'(60000 + m));
			write_reg(CFG_ALPHA_RELEASE, 16'd65000);
			run_phase(150);
		end

		// Extreme settings
		write_reg(CFG_THRESHOLD_DB, 16'h8800);
		write_reg(CFG_COMP_FACTOR, 16'hFFFF);
		write_reg(CFG_KNEE_HALF_WIDTH, 16'd12800);
		write_reg(CFG_KNEE_COEF, 16'hFFFF);
		write_reg(CFG_ALPHA_ATTACK, 16'hFFFF);
		write_reg(CFG_ALPHA_RELEASE, 16'h0000);
		run_phase(150);
		write_reg(CFG_MODE, 16'(MODE_BRANCH));
		write_reg(CFG_ALPHA_ATTACK, 16'h0000);
		write_reg(CFG_ALPHA_RELEASE, 16'hFFFF);
		write_reg(CFG_THRESHOLD_DB, 16'h0000);
		write_reg(CFG_COMP_FACTOR, 16'h0000);
		write_reg(CFG_KNEE_HALF_WIDTH, 16'd0);
		run_phase(100);
		write_reg(CFG_THRESHOLD_DB, 16'h8800);
		write_reg(CFG_COMP_FACTOR, 16'hFFFF);
		run_phase(100);

		// Random settings
		for (int k = 0; k < 8; k++) begin
			write_reg(CFG_MODE, 16'($urandom_range(0, 3)));
			write_reg(CFG_THRESHOLD_DB, 16'(-$urandom_range(0, 30720)));
			write_reg(CFG_COMP_FACTOR, 16'($urandom));
			write_reg(CFG_KNEE_HALF_WIDTH, 16'($urandom_range(0, 12800)));
			write_reg(CFG_KNEE_COEF, 16'($urandom));
			write_reg(CFG_ALPHA_ATTACK, 16'($urandom_range(0, 1) ? 65535 - $urandom_range(0, 3000)
				: $urandom));
			write_reg(CFG_ALPHA_RELEASE, 16'($urandom_range(0, 1) ? 65535 - $urandom_range(0, 300)
				: $urandom));
			run_phase(100);
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/ffac_pkg.sv
rtl/core/ffac_fifo.sv
rtl/core/ffac_front.sv
rtl/core/ffac_back.sv
rtl/core/feedforward_audio_compressor.sv
verif/tb_feedforward_audio_compressor.sv
